// ===== rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// Bicubic scaler package
// Shared types, field widths and register codes of the bicubic image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_SRC_WIDTH_DEF  = 256;
  localparam int MAX_SRC_HEIGHT_DEF = 256;
  localparam int CHANNELS_DEF       = 3;
  localparam int QUEUE_DEPTH        = 4;

  localparam int POS_W   = 12;
  localparam int SCALE_W = 24;
  localparam int PROD_W  = POS_W + SCALE_W;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = PROD_W - FRAC_W;
  localparam int WGT_W   = 16;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_INV_SCALE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    K_LOAD  = 2'd0,
    K_REQ   = 2'd1,
    K_BLANK = 2'd2
  } kind_t;

  typedef struct packed {
    logic              opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  col_out;
    logic [POS_W-1:0]  row_out;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic              in_range;
  } out_t;

  typedef struct packed {
    logic [8:0]         src_width;
    logic [8:0]         src_height;
    logic [12:0]        out_width;
    logic [12:0]        out_height;
    logic [SCALE_W-1:0] inv_scale;
  } cfg_t;

  typedef struct packed {
    kind_t                          kind;
    in_t                            cmd;
    logic [INT_W-1:0]               ix;
    logic [INT_W-1:0]               iy;
    logic signed [3:0][WGT_W-1:0]   wx;
    logic signed [3:0][WGT_W-1:0]   wy;
  } qitem_t;

endpackage

// ===== rtl/bis_front.sv =====
// ----------------------------------------------------------------------------
// Bicubic scaler front end
// Accepts commands, drops loads outside the frame, maps requests into the
// source frame and works out the Q2.14 kernel weights of both axes.
// ----------------------------------------------------------------------------
module bis_front #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  bis_pkg::in_t                             cmd,
  input  bis_pkg::cfg_t                            cfg,
  input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]       sw_eff,
  input  logic [$clog2(MAX_SRC_HEIGHT+1)-1:0]      sh_eff,
  output logic                                     push,
  output bis_pkg::qitem_t                          item,
  input  logic                                     full
);
  import bis_pkg::*;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL  = 6'b000010,
    F_SQ   = 6'b000100,
    F_CUBE = 6'b001000,
    F_WGT  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t                   state;
  logic                      axis;
  logic [PROD_W-1:0]         p;
  logic [2*FRAC_W-1:0]       f2;
  logic [3*FRAC_W-1:0]       f3;
  logic [POS_W-1:0]          pos_sel;
  logic                      load_ok;
  logic                      req_ok;
  logic signed [53:0]        t3;
  logic signed [53:0]        t2s;
  logic signed [53:0]        t1ss;
  logic signed [53:0]        n [4];
  logic signed [53:0]        r [4];
  logic signed [3:0][WGT_W-1:0] wcalc;

  assign busy    = (state != F_IDLE);
  assign push    = (state == F_PUSH) && !full;
  assign pos_sel = axis ? item.cmd.pos_y : item.cmd.pos_x;
  assign load_ok = ({1'b0, cmd.pos_x} < 13'(sw_eff)) && ({1'b0, cmd.pos_y} < 13'(sh_eff));
  assign req_ok  = ({1'b0, cmd.pos_x} < cfg.out_width) && ({1'b0, cmd.pos_y} < cfg.out_height);

  always_comb begin
    t3   = signed'({6'b0, f3});
    t2s  = signed'({6'b0, f2, 16'b0});
    t1ss = signed'({6'b0, p[FRAC_W-1:0], 32'b0});
    n[0] = (t2s <<< 1) - t3 - t1ss;
    n[1] = t3 + (t3 <<< 1) - (t2s <<< 2) - t2s + (54'sd1 <<< 49);
    n[2] = (t2s <<< 2) + t1ss - t3 - (t3 <<< 1);
    n[3] = t3 - t2s;
    for (int k = 0; k < 4; k++) begin
      r[k]     = (n[k] + (54'sd1 <<< 34)) >>> 35;
      wcalc[k] = r[k][WGT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      axis  <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            item.cmd <= cmd;
            axis     <= 1'b0;
            if (cmd.opcode == OP_LOAD) begin
              if (load_ok) begin
                item.kind <= K_LOAD;
                state     <= F_PUSH;
              end
            end else if (req_ok) begin
              item.kind <= K_REQ;
              state     <= F_MUL;
            end else begin
              item.kind <= K_BLANK;
              state     <= F_PUSH;
            end
          end
        end
        F_MUL: begin
          p     <= {{SCALE_W{1'b0}}, pos_sel} * {{POS_W{1'b0}}, cfg.inv_scale};
          state <= F_SQ;
        end
        F_SQ: begin
          f2 <= {{FRAC_W{1'b0}}, p[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, p[FRAC_W-1:0]};
          if (axis) begin
            item.iy <= p[PROD_W-1:FRAC_W];
          end else begin
            item.ix <= p[PROD_W-1:FRAC_W];
          end
          state <= F_CUBE;
        end
        F_CUBE: begin
          f3    <= {{FRAC_W{1'b0}}, f2} * {{2*FRAC_W{1'b0}}, p[FRAC_W-1:0]};
          state <= F_WGT;
        end
        F_WGT: begin
          if (axis) begin
            item.wy <= wcalc;
            state   <= F_PUSH;
          end else begin
            item.wx <= wcalc;
            axis    <= 1'b1;
            state   <= F_MUL;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bis_queue.sv =====
// ----------------------------------------------------------------------------
// Bicubic scaler queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module bis_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bis_pkg::qitem_t item,
  output logic            full,
  input  logic            pop,
  output bis_pkg::qitem_t head,
  output logic            empty
);
  import bis_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qitem_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bis_back.sv =====
// ----------------------------------------------------------------------------
// Bicubic scaler back end
// Holds the source frame, writes loads and runs the sixteen-tap weighted sum
// of each request through a read, multiply and accumulate pipeline.
// ----------------------------------------------------------------------------
module bis_back #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int CHANNELS       = bis_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [$clog2(MAX_SRC_WIDTH+1)-1:0]  sw_eff,
  input  logic [$clog2(MAX_SRC_HEIGHT+1)-1:0] sh_eff,
  input  bis_pkg::qitem_t                     head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                result_valid,
  output bis_pkg::out_t                       result
);
  import bis_pkg::*;

  localparam int XW    = $clog2(MAX_SRC_WIDTH);
  localparam int YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int AW    = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int DW    = 8 * CHANNELS;
  localparam int ACC_W = 44;
  localparam int CW    = INT_W + 2;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_RUN   = 3'b010,
    B_DRAIN = 3'b100
  } bstate_t;

  bstate_t                     state;
  qitem_t                      cur;
  logic [3:0]                  tap;
  logic                        v1;
  logic                        v2;
  logic [DW-1:0]               mem [DEPTH];
  logic [DW-1:0]               mem_q;
  logic                        we;
  logic [AW-1:0]               wr_addr;
  logic [DW-1:0]               wr_data;
  logic [AW-1:0]               rd_addr;
  logic signed [CW-1:0]        cx;
  logic signed [CW-1:0]        cy;
  logic [XW-1:0]               px;
  logic [YW-1:0]               py;
  logic signed [2*WGT_W-1:0]   wp1;
  logic signed [40:0]          prod [CHANNELS];
  logic signed [ACC_W-1:0]     acc [CHANNELS];
  logic [2:0][7:0]             lanes;

  assign pop     = (state == B_IDLE) && !empty;
  assign we      = pop && (head.kind == K_LOAD);
  assign wr_addr = AW'(head.cmd.pos_y[YW-1:0]) * AW'(MAX_SRC_WIDTH)
                 + AW'(head.cmd.pos_x[XW-1:0]);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_wr
    if (c == 0) begin : g_r
      assign wr_data[8*c +: 8] = head.cmd.red_in;
    end else if (c == 1) begin : g_g
      assign wr_data[8*c +: 8] = head.cmd.green_in;
    end else if (c == 2) begin : g_b
      assign wr_data[8*c +: 8] = head.cmd.blue_in;
    end else begin : g_z
      assign wr_data[8*c +: 8] = 8'd0;
    end
  end

  always_comb begin
    cx = signed'({2'b00, cur.ix}) - CW'(1) + CW'(tap[1:0]);
    cy = signed'({2'b00, cur.iy}) - CW'(1) + CW'(tap[3:2]);
    if (cx < 0) begin
      px = '0;
    end else if (cx >= signed'(CW'(sw_eff))) begin
      px = XW'(sw_eff - 1'b1);
    end else begin
      px = cx[XW-1:0];
    end
    if (cy < 0) begin
      py = '0;
    end else if (cy >= signed'(CW'(sh_eff))) begin
      py = YW'(sh_eff - 1'b1);
    end else begin
      py = cy[YW-1:0];
    end
    rd_addr = AW'(py) * AW'(MAX_SRC_WIDTH) + AW'(px);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == B_RUN) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    wp1 <= signed'(cur.wx[tap[1:0]]) * signed'(cur.wy[tap[3:2]]);
    for (int c = 0; c < CHANNELS; c++) begin
      prod[c] <= wp1 * signed'({1'b0, mem_q[8*c +: 8]});
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      assign lanes[c] = acc[c][ACC_W-1] ? 8'd0 :
                        (acc[c][ACC_W-2:36] != '0) ? 8'd255 : acc[c][35:28];
    end else begin : g_off
      assign lanes[c] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
      tap          <= '0;
    end else begin
      result_valid <= 1'b0;
      v1           <= (state == B_RUN);
      v2           <= v1;
      if (v2) begin
        for (int c = 0; c < CHANNELS; c++) begin
          acc[c] <= acc[c] + ACC_W'(prod[c]);
        end
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            case (head.kind)
              K_REQ: begin
                cur   <= head;
                tap   <= '0;
                state <= B_RUN;
                for (int c = 0; c < CHANNELS; c++) begin
                  acc[c] <= '0;
                end
              end
              K_BLANK: begin
                result.col_out   <= head.cmd.pos_x;
                result.row_out   <= head.cmd.pos_y;
                result.red_out   <= 8'd0;
                result.green_out <= 8'd0;
                result.blue_out  <= 8'd0;
                result.in_range  <= 1'b0;
                result_valid     <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        B_RUN: begin
          tap <= tap + 1'b1;
          if (tap == 4'd15) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (!v1 && !v2) begin
            result.col_out   <= cur.cmd.pos_x;
            result.row_out   <= cur.cmd.pos_y;
            result.red_out   <= lanes[0];
            result.green_out <= lanes[1];
            result.blue_out  <= lanes[2];
            result.in_range  <= 1'b1;
            result_valid     <= 1'b1;
            state            <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bicubic_image_scaler.sv =====
// ----------------------------------------------------------------------------
// Bicubic image scaler
// Stores an RGB source frame and computes scaled output pixels with the
// Keys cubic kernel over a four by four neighbourhood.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Transfer
//  command   start, busy, cmd                     start high while busy low
//  result    result_valid, result                 one-cycle strobe, no stall
//  config    cfg_we, cfg_index, cfg_data          cfg_we high, no wait
//
// A load passes through the front end and the queue to the back end's frame.
// A request gets its position and weights in the front end, axis by axis, then
// sixteen single-port frame reads and a multiply and accumulate drain in the
// back end, which takes the next queued item only when the last one is done.
// Reset restores the register defaults; the frame memory is not cleared.
// The result strobe lasts exactly one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module bicubic_image_scaler #(
  parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int CHANNELS       = bis_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  bis_pkg::in_t                 cmd,
  output logic                         result_valid,
  output bis_pkg::out_t                result,
  input  logic                         cfg_we,
  input  logic [bis_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bis_pkg::CFG_W-1:0]    cfg_data
);
  import bis_pkg::*;

  localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);

  cfg_t            cfg;
  logic [SWW-1:0]  sw_eff;
  logic [SHW-1:0]  sh_eff;
  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  qitem_t          item;
  qitem_t          head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width  <= 9'd256;
      cfg.src_height <= 9'd256;
      cfg.out_width  <= 13'd256;
      cfg.out_height <= 13'd256;
      cfg.inv_scale  <= 24'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  cfg.src_width  <= cfg_data[8:0];
        REG_SRC_HEIGHT: cfg.src_height <= cfg_data[8:0];
        REG_OUT_WIDTH:  cfg.out_width  <= cfg_data[12:0];
        REG_OUT_HEIGHT: cfg.out_height <= cfg_data[12:0];
        REG_INV_SCALE:  cfg.inv_scale  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cfg.src_width == '0) begin
      sw_eff = SWW'(1);
    end else if ({4'b0, cfg.src_width} > 13'(MAX_SRC_WIDTH)) begin
      sw_eff = SWW'(MAX_SRC_WIDTH);
    end else begin
      sw_eff = SWW'(cfg.src_width);
    end
    if (cfg.src_height == '0) begin
      sh_eff = SHW'(1);
    end else if ({4'b0, cfg.src_height} > 13'(MAX_SRC_HEIGHT)) begin
      sh_eff = SHW'(MAX_SRC_HEIGHT);
    end else begin
      sh_eff = SHW'(cfg.src_height);
    end
  end

  bis_front #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .cfg    (cfg),
    .sw_eff (sw_eff),
    .sh_eff (sh_eff),
    .push   (push),
    .item   (item),
    .full   (full)
  );

  bis_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .item  (item),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  bis_back #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .CHANNELS       (CHANNELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .sw_eff       (sw_eff),
    .sh_eff       (sh_eff),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
